[src/maglev_backend_table_top_assert.svh]
// Assertion macros for the backend table.
`ifndef MAGLEV_BACKEND_TABLE_TOP_ASSERT_SVH
`define MAGLEV_BACKEND_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MLB_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MLB_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define MLB_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define MLB_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`endif
`endif

[src/mlb_pkg.sv]
package mlb_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_PRESENT = 3'd1,
      STATUS_MISSING = 3'd2,
      STATUS_FULL    = 3'd3,
      STATUS_EMPTY   = 3'd4
   } status_type;

   localparam logic [63:0] SIP_K0 = 64'h0706050403020100;
   localparam logic [63:0] SIP_K1 = 64'h0F0E0D0C0B0A0908;
   localparam logic [63:0] SIP_V0 = SIP_K0 ^ 64'h736f6d6570736575;
   localparam logic [63:0] SIP_V1 = SIP_K1 ^ 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_V2 = SIP_K0 ^ 64'h6c7967656e657261;
   localparam logic [63:0] SIP_V3 = SIP_K1 ^ 64'h7465646279746573;

   localparam logic [3:0] KEY_FULL_LEN = 4'd8;
   localparam logic [10:0] TABLE_SIZE_RESET = 11'd1021;

   // Hash request from the sequencer to the hash unit
   typedef struct packed {
      logic        start;
      logic [63:0] data;
      logic [3:0]  len;
   } sip_req_type;

   typedef logic [3:0][63:0] sip_state_type;

endpackage

[src/maglev_backend_table_top.sv]
// Maglev backend table. Add and remove edit an ordered list of up to MAX_BACKENDS
// ids and, when they succeed, rebuild the slot table: each id gets one SipHash and
// two remainder passes through the shared bit-serial divider, then a clearing
// sweep wipes the M slots in use, then a claim walk reads the slot memory once per
// probed slot (S_CL_CHECK, then S_CL_WAIT). A refused add or remove ends after the
// list scan. A lookup takes a hash (short keys need one compression block, eight-
// byte keys two), a remainder by the built table size, one slot memory read and the
// response load. One item is worked at a time; the response register frees the
// result side. A new table_size takes effect at the next rebuild.
`include "maglev_backend_table_top_assert.svh"
module maglev_backend_table_top #(
   parameter int MAX_BACKENDS = 16,
   parameter int TABLE_DEPTH  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [62:0] req_backend_ident,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [62:0] rsp_chosen_backend,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_write_data
);

   localparam int IDX_W  = $clog2(MAX_BACKENDS);
   localparam int CNT_W  = $clog2(MAX_BACKENDS + 1);
   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int MW     = $clog2(TABLE_DEPTH + 1);
   localparam int RAM_W  = IDX_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_RB_START, S_RB_HSTART, S_RB_HASH, S_RB_DIV1,
      S_RB_DIV2, S_CLEAR, S_CL_CHECK, S_CL_WAIT, S_LK_HASH, S_LK_DIV, S_LK_RD,
      S_RESP
   } state_type;

   state_type           state_ff;
   logic [10:0]         table_size_ff;
   logic [1:0]          op_ff;
   logic [62:0]         id_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    fpos_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [62:0]         ids_ff  [MAX_BACKENDS];
   logic [SLOT_W-1:0]   pos_ff  [MAX_BACKENDS];
   logic [SLOT_W-1:0]   skip_ff [MAX_BACKENDS];
   logic [MW-1:0]       cur_ff  [MAX_BACKENDS];
   logic [MW-1:0]       built_ff;
   logic [MW-1:0]       m_ff;
   logic [63:0]         h_ff;
   logic [SLOT_W-1:0]   addr_ff;
   logic [MW-1:0]       claimed_ff;
   logic                progress_ff;
   logic [SLOT_W-1:0]   s_ff;
   mlb_pkg::status_type res_status_ff;
   logic [62:0]         res_chosen_ff;
   logic                rsp_valid_ff;
   mlb_pkg::status_type rsp_status_ff;
   logic [62:0]         rsp_chosen_ff;
   mlb_pkg::sip_req_type sip_req_ff;
   logic                div_start_ff;
   logic [63:0]         div_dvd_ff;
   logic [MW-1:0]       div_dvs_ff;

   logic                sip_done;
   logic [63:0]         sip_hash;
   logic                div_done;
   logic [MW-1:0]       div_rem;
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_waddr;
   logic [RAM_W-1:0]    ram_wdata;
   logic [SLOT_W-1:0]   ram_raddr;
   logic [RAM_W-1:0]    ram_rdata;
   logic [MW-1:0]       m_new;
   logic [IDX_W-1:0]    idx;
   logic [IDX_W-1:0]    owner;
   logic [MW:0]         pos_sum;
   logic [SLOT_W-1:0]   pos_next;
   logic                sip_start_in;
   logic                div_start_in;

   mlb_siphash u_sip (
      .clock (clock),
      .reset (reset),
      .req   (sip_req_ff),
      .done  (sip_done),
      .hash  (sip_hash)
   );

   mlb_mod #(.DW(MW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (div_dvs_ff),
      .done     (div_done),
      .rem      (div_rem)
   );

   // slot memory: claimed flag over owner position
   mlb_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign idx = idx_ff[IDX_W-1:0];

   // clamp the configured size into 2..TABLE_DEPTH
   always_comb begin
      if (table_size_ff < 11'd2) begin
         m_new = MW'(2);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         m_new = MW'(TABLE_DEPTH);
      end else begin
         m_new = MW'(table_size_ff);
      end
   end

   // step the probe position of the current backend
   always_comb begin
      pos_sum = (MW + 1)'(pos_ff[idx]) + (MW + 1)'(skip_ff[idx]);
      if (pos_sum >= (MW + 1)'(m_ff)) begin
         pos_next = SLOT_W'(pos_sum - (MW + 1)'(m_ff));
      end else begin
         pos_next = SLOT_W'(pos_sum);
      end
   end

   // start pulses for the hash unit and the remainder unit
   always_comb begin
      sip_start_in = (state_ff == S_RB_HSTART) ||
                     ((state_ff == S_IDLE) && req_valid &&
                      (req_opcode == mlb_pkg::OP_LOOKUP) &&
                      (count_ff != '0) && (built_ff != '0));
      div_start_in = (((state_ff == S_RB_HASH) || (state_ff == S_LK_HASH)) && sip_done) ||
                     ((state_ff == S_RB_DIV1) && div_done);
   end

   // slot memory ports
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = '0;
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
      end else if ((state_ff == S_CL_WAIT) && !ram_rdata[IDX_W]) begin
         ram_we    = 1'b1;
         ram_waddr = s_ff;
         ram_wdata = {1'b1, idx};
      end
      ram_raddr = (state_ff == S_LK_DIV) ? div_rem[SLOT_W-1:0] : pos_ff[idx];
   end

   // an owner beyond the list answers as position zero
   always_comb begin
      owner = ram_rdata[IDX_W-1:0];
      if (CNT_W'(owner) >= count_ff) begin
         owner = '0;
      end
   end

   // hold the size register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= mlb_pkg::TABLE_SIZE_RESET;
      end else if (csr_write_enable) begin
         table_size_ff <= csr_write_data;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= '0;
         built_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         sip_req_ff.start <= 1'b0;
         div_start_ff     <= 1'b0;
      end else begin
         sip_req_ff.start <= sip_start_in;
         div_start_ff     <= div_start_in;
         if (rsp_valid_ff && rsp_ready && (state_ff != S_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_opcode;
                  id_ff         <= req_backend_ident;
                  idx_ff        <= '0;
                  found_ff      <= 1'b0;
                  fpos_ff       <= '0;
                  res_status_ff <= mlb_pkg::STATUS_OK;
                  res_chosen_ff <= '0;
                  unique case (req_opcode)
                     mlb_pkg::OP_ADD, mlb_pkg::OP_REMOVE: state_ff <= S_SCAN;
                     mlb_pkg::OP_LOOKUP: begin
                        if ((count_ff == '0) || (built_ff == '0)) begin
                           res_status_ff <= mlb_pkg::STATUS_EMPTY;
                           state_ff      <= S_RESP;
                        end else begin
                           sip_req_ff.data  <= req_key_bytes;
                           sip_req_ff.len   <= (req_key_length > mlb_pkg::KEY_FULL_LEN) ?
                                               mlb_pkg::KEY_FULL_LEN : req_key_length;
                           state_ff         <= S_LK_HASH;
                        end
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            // look for the id, one list entry a cycle
            S_SCAN: begin
               if (idx_ff == count_ff) begin
                  state_ff <= S_DECIDE;
               end else if (ids_ff[idx] == id_ff) begin
                  found_ff <= 1'b1;
                  fpos_ff  <= idx;
                  state_ff <= S_DECIDE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DECIDE: begin
               if (op_ff == mlb_pkg::OP_ADD) begin
                  if (found_ff) begin
                     res_status_ff <= mlb_pkg::STATUS_PRESENT;
                     state_ff      <= S_RESP;
                  end else if (count_ff >= CNT_W'(MAX_BACKENDS)) begin
                     res_status_ff <= mlb_pkg::STATUS_FULL;
                     state_ff      <= S_RESP;
                  end else begin
                     ids_ff[count_ff[IDX_W-1:0]] <= id_ff;
                     count_ff <= count_ff + 1'b1;
                     state_ff <= S_RB_START;
                  end
               end else begin
                  if (!found_ff) begin
                     res_status_ff <= mlb_pkg::STATUS_MISSING;
                     state_ff      <= S_RESP;
                  end else begin
                     // close the gap, keep the order
                     for (int j = 0; j < MAX_BACKENDS - 1; j++) begin
                        if (j >= int'(fpos_ff)) begin
                           ids_ff[j] <= ids_ff[j + 1];
                        end
                     end
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_RB_START;
                  end
               end
            end
            S_RB_START: begin
               built_ff <= m_new;
               m_ff     <= m_new;
               idx_ff   <= '0;
               if (count_ff == '0) begin
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_RB_HSTART;
               end
            end
            S_RB_HSTART: begin
               sip_req_ff.data  <= {1'b0, ids_ff[idx]};
               sip_req_ff.len   <= mlb_pkg::KEY_FULL_LEN;
               state_ff         <= S_RB_HASH;
            end
            S_RB_HASH: begin
               if (sip_done) begin
                  h_ff         <= sip_hash;
                  div_dvd_ff   <= sip_hash;
                  div_dvs_ff   <= m_ff;
                  state_ff     <= S_RB_DIV1;
               end
            end
            S_RB_DIV1: begin
               if (div_done) begin
                  pos_ff[idx]  <= div_rem[SLOT_W-1:0];
                  div_dvd_ff   <= h_ff;
                  div_dvs_ff   <= m_ff - 1'b1;
                  state_ff     <= S_RB_DIV2;
               end
            end
            S_RB_DIV2: begin
               if (div_done) begin
                  skip_ff[idx] <= SLOT_W'(div_rem + 1'b1);
                  cur_ff[idx]  <= '0;
                  if (idx_ff + 1'b1 == count_ff) begin
                     addr_ff  <= '0;
                     state_ff <= S_CLEAR;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_RB_HSTART;
                  end
               end
            end
            // wipe the slots in use
            S_CLEAR: begin
               if (MW'(addr_ff) == m_ff - 1'b1) begin
                  idx_ff      <= '0;
                  claimed_ff  <= '0;
                  progress_ff <= 1'b0;
                  state_ff    <= S_CL_CHECK;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            // backends take turns; each probes until it claims one slot
            S_CL_CHECK: begin
               priority if (idx_ff == count_ff) begin
                  if (progress_ff && (claimed_ff < m_ff)) begin
                     idx_ff      <= '0;
                     progress_ff <= 1'b0;
                  end else begin
                     state_ff <= S_RESP;
                  end
               end else if (claimed_ff >= m_ff) begin
                  state_ff <= S_RESP;
               end else if (cur_ff[idx] >= m_ff) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  s_ff        <= pos_ff[idx];
                  pos_ff[idx] <= pos_next;
                  cur_ff[idx] <= cur_ff[idx] + 1'b1;
                  state_ff    <= S_CL_WAIT;
               end
            end
            S_CL_WAIT: begin
               if (!ram_rdata[IDX_W]) begin
                  claimed_ff  <= claimed_ff + 1'b1;
                  progress_ff <= 1'b1;
                  idx_ff      <= idx_ff + 1'b1;
               end
               state_ff <= S_CL_CHECK;
            end
            S_LK_HASH: begin
               if (sip_done) begin
                  div_dvd_ff   <= {32'd0, sip_hash[31:0]};
                  div_dvs_ff   <= built_ff;
                  state_ff     <= S_LK_DIV;
               end
            end
            S_LK_DIV: begin
               if (div_done) begin
                  state_ff <= S_LK_RD;
               end
            end
            S_LK_RD: begin
               res_chosen_ff <= ids_ff[owner];
               state_ff      <= S_RESP;
            end
            // transfer into the response register once it is free
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_chosen_ff <= res_chosen_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chosen_backend = rsp_chosen_ff;

   `MLB_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_BACKENDS),
                      "backend count overflow")
   `MLB_ASSERT_IMPLY(a_write_in_table, clock, reset, ram_we, MW'(ram_waddr) < m_ff,
                     "slot write beyond table size")
   `MLB_ASSERT_IMPLY(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff == S_RESP), "response loaded outside response state")

endmodule

[src/mlb_ram.sv]
module mlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mlb_siphash.sv]
module mlb_siphash (
   input  logic                clock,
   input  logic                reset,
   input  mlb_pkg::sip_req_type req,
   output logic                done,
   output logic [63:0]         hash
);

   typedef enum logic [2:0] {
      S_IDLE, S_MIN, S_RND, S_MOUT, S_FIN, S_FRND, S_DONE
   } state_type;

   state_type             state_ff;
   mlb_pkg::sip_state_type v_ff;
   logic [63:0]           m_ff;
   logic [63:0]           tail_ff;
   logic                  last_ff;
   logic [1:0]            cnt_ff;
   logic [63:0]           tail;
   mlb_pkg::sip_state_type v_rnd;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic mlb_pkg::sip_state_type sip_round(input mlb_pkg::sip_state_type v);
      logic [63:0] a, b, c, d;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
      c = c + d; d = rotl(d, 16); d = d ^ c;
      a = a + d; d = rotl(d, 21); d = d ^ a;
      c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
      return {d, c, b, a};
   endfunction

   // final block: length in the top byte, unused key bytes masked
   always_comb begin
      tail = '0;
      for (int b = 0; b < 7; b++) begin
         if ((req.len < mlb_pkg::KEY_FULL_LEN) && (4'(b) < req.len)) begin
            tail[8*b +: 8] = req.data[8*b +: 8];
         end
      end
      tail[63:56] = {4'd0, req.len};
   end

   assign v_rnd = sip_round(v_ff);

   // one round a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  v_ff    <= {mlb_pkg::SIP_V3, mlb_pkg::SIP_V2, mlb_pkg::SIP_V1,
                              mlb_pkg::SIP_V0};
                  m_ff    <= (req.len >= mlb_pkg::KEY_FULL_LEN) ? req.data : tail;
                  tail_ff <= tail;
                  last_ff <= (req.len < mlb_pkg::KEY_FULL_LEN);
                  state_ff <= S_MIN;
               end
            end
            S_MIN: begin
               v_ff[3]  <= v_ff[3] ^ m_ff;
               cnt_ff   <= 2'd0;
               state_ff <= S_RND;
            end
            S_RND: begin
               v_ff   <= v_rnd;
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd1) begin
                  state_ff <= S_MOUT;
               end
            end
            S_MOUT: begin
               v_ff[0] <= v_ff[0] ^ m_ff;
               if (last_ff) begin
                  state_ff <= S_FIN;
               end else begin
                  m_ff     <= tail_ff;
                  last_ff  <= 1'b1;
                  state_ff <= S_MIN;
               end
            end
            S_FIN: begin
               v_ff[2]  <= v_ff[2] ^ 64'hff;
               cnt_ff   <= 2'd0;
               state_ff <= S_FRND;
            end
            S_FRND: begin
               v_ff   <= v_rnd;
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = (state_ff == S_DONE);
   assign hash = v_ff[0] ^ v_ff[1] ^ v_ff[2] ^ v_ff[3];

endmodule

[src/mlb_mod.sv]
module mlb_mod #(
   parameter int DW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] rem
);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_type;

   state_type     state_ff;
   logic [63:0]   dvd_ff;
   logic [DW-1:0] dvs_ff;
   logic [DW-1:0] rem_ff;
   logic [6:0]    cnt_ff;
   logic [DW:0]   trial;

   assign trial = {rem_ff, dvd_ff[63]};

   // restoring remainder, one dividend bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dvd_ff   <= dividend;
                  dvs_ff   <= divisor;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               dvd_ff <= {dvd_ff[62:0], 1'b0};
               if (trial >= {1'b0, dvs_ff}) begin
                  rem_ff <= DW'(trial - {1'b0, dvs_ff});
               end else begin
                  rem_ff <= DW'(trial);
               end
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = (state_ff == S_DONE);
   assign rem  = rem_ff;

endmodule
